FILE: sv/crb_pkg.sv
// Shared types and constants of the cubic root bisection block.
// No dependencies; imported by crb_cfg_regs, crb_horner and cubic_root_bisection.
package crb_pkg;

    localparam int DEF_VALUE_WIDTH   = 32;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int COEF_W     = 32;
    localparam int X_W        = 32;
    localparam int TOL_W      = 31;
    localparam int LIMIT_W    = 8;
    localparam int STEP_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RES_W      = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    localparam logic signed [63:0] RES_MAX = 64'sd2147483647;
    localparam logic signed [63:0] RES_MIN = -64'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUBIC  = 3'd0,
        CFG_SQUARE = 3'd1,
        CFG_LINEAR = 3'd2,
        CFG_CONST  = 3'd3,
        CFG_TOL    = 3'd4,
        CFG_LIMIT  = 3'd5
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_CONVERGED = 2'd0,
        ST_NO_SIGN   = 2'd1,
        ST_LIMIT     = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COEF_W-1:0] cubic;
        logic signed [COEF_W-1:0] square;
        logic signed [COEF_W-1:0] linear;
        logic signed [COEF_W-1:0] const_term;
    } t_coefs;

    typedef struct packed {
        logic                  kick;
        logic signed [X_W-1:0] x;
    } t_hrn_req;

endpackage

FILE: sv/crb_cfg_regs.sv
// Configuration register file: coefficients, tolerance and iteration limit.
// Depends on crb_pkg.
module crb_cfg_regs #(
    parameter int FRACTION_BITS = crb_pkg::DEF_FRACTION_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [crb_pkg::CFG_IDX_W-1:0]      i_wr_index,
    input  logic [crb_pkg::CFG_DATA_W-1:0]     i_wr_data,
    output crb_pkg::t_coefs                    o_coefs,
    output logic [crb_pkg::TOL_W-1:0]          o_tolerance,
    output logic [crb_pkg::LIMIT_W-1:0]        o_limit
);
    import crb_pkg::*;

    // round(0.001 * 2^F)
    localparam logic [TOL_W-1:0] TOL_RESET =
        TOL_W'(((64'd1 << FRACTION_BITS) + 64'd500) / 64'd1000);

    t_coefs             r_coefs;
    logic [TOL_W-1:0]   r_tol;
    logic [LIMIT_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
            r_tol   <= TOL_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_CUBIC:  r_coefs.cubic      <= signed'(i_wr_data);
                CFG_SQUARE: r_coefs.square     <= signed'(i_wr_data);
                CFG_LINEAR: r_coefs.linear     <= signed'(i_wr_data);
                CFG_CONST:  r_coefs.const_term <= signed'(i_wr_data);
                CFG_TOL:    r_tol              <= i_wr_data[TOL_W-1:0];
                CFG_LIMIT:  r_limit            <= i_wr_data[LIMIT_W-1:0];
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    assign o_coefs     = r_coefs;
    assign o_tolerance = r_tol;
    assign o_limit     = r_limit;

endmodule

FILE: sv/crb_horner.sv
// Shared multiply unit evaluating the cubic by Horner's rule, one product at a time.
// Depends on crb_pkg.
module crb_horner #(
    parameter int VALUE_WIDTH   = crb_pkg::DEF_VALUE_WIDTH,
    parameter int FRACTION_BITS = crb_pkg::DEF_FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crb_pkg::t_hrn_req             i_req,
    input  crb_pkg::t_coefs               i_coefs,
    output logic                          o_done,
    output logic signed [VALUE_WIDTH-1:0] o_value
);
    import crb_pkg::*;

    localparam int CHUNKS  = (VALUE_WIDTH + 31) / 32;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int MAG_W   = 32 * CHUNKS;
    localparam int PROD_W  = MAG_W + X_W;

    localparam logic [PROD_W-1:0]   CAP    = PROD_W'(1) << (VALUE_WIDTH - 1);
    localparam logic signed [63:0]  SAT_HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0]  SAT_LO = -(64'sd1 <<< (VALUE_WIDTH - 1));
    localparam logic [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_MUL  = 3'b010,
        H_ADD  = 3'b100
    } t_hrn_phase;

    function automatic logic signed [VALUE_WIDTH-1:0] sat_coef(
        input logic signed [COEF_W-1:0] c
    );
        logic signed [63:0] c64;
        begin
            c64 = 64'(c);
            if (c64 > SAT_HI)
                return SAT_HI[VALUE_WIDTH-1:0];
            else if (c64 < SAT_LO)
                return SAT_LO[VALUE_WIDTH-1:0];
            else
                return c64[VALUE_WIDTH-1:0];
        end
    endfunction

    t_hrn_phase                    r_phase;
    logic                          r_done;
    logic [1:0]                    r_term;
    logic [CHUNK_W-1:0]            r_chunk;
    logic signed [VALUE_WIDTH-1:0] r_acc;
    logic [X_W-1:0]                r_xmag;
    logic                          r_xneg;
    logic [PROD_W-1:0]             r_prod;

    logic                          acc_neg;
    logic [VALUE_WIDTH-1:0]        acc_mag;
    logic [MAG_W-1:0]              acc_pad;
    logic [31:0]                   chunk;
    logic [63:0]                   pp;
    logic [PROD_W-1:0]             pp_shift;
    logic [PROD_W-1:0]             mag_sh;
    logic                          prod_neg;
    logic [VALUE_WIDTH-1:0]        m;
    logic signed [VALUE_WIDTH-1:0] coef;
    logic [VALUE_WIDTH:0]          sum;
    logic [VALUE_WIDTH-1:0]        sum_sat;
    logic [X_W-1:0]                x_mag;

    // multiply stage: one 32-bit chunk of |acc| against |x| per cycle
    assign acc_neg  = r_acc[VALUE_WIDTH-1];
    assign acc_mag  = acc_neg ? (~r_acc + 1'b1) : r_acc;
    assign acc_pad  = MAG_W'(acc_mag);
    assign chunk    = acc_pad[32*r_chunk +: 32];
    assign pp       = chunk * r_xmag;
    assign pp_shift = PROD_W'(pp) << (32 * r_chunk);

    // add stage: truncate toward zero, saturate, add coefficient, saturate
    assign mag_sh   = r_prod >> FRACTION_BITS;
    assign prod_neg = acc_neg ^ r_xneg;

    always_comb begin
        if (mag_sh >= CAP)
            m = prod_neg ? V_MIN : V_MAX;
        else if (prod_neg)
            m = ~mag_sh[VALUE_WIDTH-1:0] + 1'b1;
        else
            m = mag_sh[VALUE_WIDTH-1:0];
    end

    always_comb begin
        case (r_term)
            2'd0:    coef = sat_coef(i_coefs.square);
            2'd1:    coef = sat_coef(i_coefs.linear);
            default: coef = sat_coef(i_coefs.const_term);
        endcase
    end

    assign sum = {m[VALUE_WIDTH-1], m} + {coef[VALUE_WIDTH-1], coef};

    always_comb begin
        if (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1])
            sum_sat = sum[VALUE_WIDTH] ? V_MIN : V_MAX;
        else
            sum_sat = sum[VALUE_WIDTH-1:0];
    end

    assign x_mag = i_req.x[X_W-1] ? (~i_req.x + 1'b1) : i_req.x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.kick) begin
                r_phase <= H_MUL;
            end else begin
                unique case (r_phase)
                    H_IDLE: r_phase <= H_IDLE;
                    H_MUL: begin
                        if (r_chunk == CHUNK_W'(CHUNKS - 1))
                            r_phase <= H_ADD;
                    end
                    H_ADD: begin
                        if (r_term == 2'd2) begin
                            r_phase <= H_IDLE;
                            r_done  <= 1'b1;
                        end else begin
                            r_phase <= H_MUL;
                        end
                    end
                    default: r_phase <= H_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.kick) begin
            r_acc   <= sat_coef(i_coefs.cubic);
            r_xmag  <= x_mag;
            r_xneg  <= i_req.x[X_W-1];
            r_term  <= 2'd0;
            r_chunk <= '0;
        end else if (r_phase == H_MUL) begin
            r_prod  <= ((r_chunk == '0) ? '0 : r_prod) + pp_shift;
            r_chunk <= (r_chunk == CHUNK_W'(CHUNKS - 1)) ? '0 : r_chunk + 1'b1;
        end else if (r_phase == H_ADD) begin
            r_acc  <= signed'(sum_sat);
            r_term <= r_term + 1'b1;
        end
    end

    assign o_done  = r_done;
    assign o_value = r_acc;

endmodule

FILE: sv/cubic_root_bisection.sv
// Top level of the cubic root bisection block: sequencer, interval registers, result beat.
// Depends on crb_pkg, crb_cfg_regs and crb_horner.
//
// Usage
//   Request: drive i_range_start / i_range_end and raise start; the beat is
//   taken at a rising edge with start high and busy low. busy rises in the
//   next cycle and stays high until the result beat.
//   Result: o_done is high for exactly one cycle with o_root, o_residual,
//   o_steps_used and o_status; the receiver cannot stall it, so sample it
//   then. busy is already low in that cycle, so a new request may be taken
//   in the very cycle the result is shown.
//   Configuration: write register i_cfg_index with i_cfg_data when
//   i_cfg_valid and o_cfg_ready are high; o_cfg_ready is always high. Write
//   only while busy is low and no result is pending.
// Evaluation
//   One evaluation of the cubic runs three products on the shared multiplier;
//   each runs a multiply phase over the C = ceil(VALUE_WIDTH/32) 32-bit chunks
//   of |acc|, then an add phase for the next coefficient. A request evaluates
//   the low end, the high end, then, if the signs differ, one midpoint per step.
// Reset
//   Synchronous, active low: the sequencer goes idle, no result is pending,
//   coefficients clear, tolerance returns to round(0.001*2^F), limit to 100.
module cubic_root_bisection #(
    parameter int VALUE_WIDTH   = crb_pkg::DEF_VALUE_WIDTH,
    parameter int FRACTION_BITS = crb_pkg::DEF_FRACTION_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [crb_pkg::X_W-1:0]        i_range_start,
    input  logic signed [crb_pkg::X_W-1:0]        i_range_end,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [crb_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [crb_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                  o_done,
    output logic signed [crb_pkg::RES_W-1:0]      o_root,
    output logic signed [crb_pkg::RES_W-1:0]      o_residual,
    output logic [crb_pkg::STEP_W-1:0]            o_steps_used,
    output logic [crb_pkg::STATUS_W-1:0]          o_status
);
    import crb_pkg::*;

    localparam int CMP_W = (VALUE_WIDTH > TOL_W) ? VALUE_WIDTH : TOL_W;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_EVAL_LO  = 5'b00010,
        S_EVAL_HI  = 5'b00100,
        S_MID      = 5'b01000,
        S_EVAL_MID = 5'b10000
    } t_seq_state;

    // Saturate a cubic value to the 32-bit residual field.
    function automatic logic [RES_W-1:0] sat_res(
        input logic signed [VALUE_WIDTH-1:0] v
    );
        logic signed [63:0] v64;
        begin
            v64 = 64'(v);
            if (v64 > RES_MAX)
                return RES_MAX[RES_W-1:0];
            else if (v64 < RES_MIN)
                return RES_MIN[RES_W-1:0];
            else
                return v64[RES_W-1:0];
        end
    endfunction

    t_coefs                        coefs;
    logic [TOL_W-1:0]              tol;
    logic [LIMIT_W-1:0]            limit;
    t_hrn_req                      h_req;
    logic                          h_done;
    logic signed [VALUE_WIDTH-1:0] h_value;

    t_seq_state                    r_state, n_state;
    logic signed [X_W-1:0]         r_low;
    logic signed [X_W-1:0]         r_high;
    logic signed [X_W-1:0]         r_mid;
    logic signed [VALUE_WIDTH-1:0] r_flo;
    logic                          r_low_sign;
    logic [STEP_W-1:0]             r_step;
    logic                          r_done;
    logic [RES_W-1:0]              r_root;
    logic [RES_W-1:0]              r_residual;
    logic [STEP_W-1:0]             r_steps_used;
    t_status                       r_status;

    logic [X_W:0]                  mid_sum;
    logic [X_W:0]                  mid_adj;
    logic signed [X_W-1:0]         mid_x;
    logic [X_W:0]                  diff;
    logic [X_W:0]                  wmag;
    logic [VALUE_WIDTH-1:0]        fmag;
    logic                          conv;
    logic                          no_sign;
    logic [STEP_W-1:0]             step_n;
    logic                          accept;

    crb_cfg_regs #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (i_cfg_valid & o_cfg_ready),
        .i_wr_index  (i_cfg_index),
        .i_wr_data   (i_cfg_data),
        .o_coefs     (coefs),
        .o_tolerance (tol),
        .o_limit     (limit)
    );

    crb_horner #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (h_req),
        .i_coefs (coefs),
        .o_done  (h_done),
        .o_value (h_value)
    );

    assign accept      = start & ~busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // midpoint of the current interval, truncated toward zero
    assign mid_sum = {r_low[X_W-1], r_low} + {r_high[X_W-1], r_high};
    assign mid_adj = mid_sum + {{X_W{1'b0}}, mid_sum[X_W]};
    assign mid_x   = signed'(mid_adj[X_W:1]);

    // stop tests: |f(mid)| and |high - low| against the tolerance
    assign diff  = {r_high[X_W-1], r_high} - {r_low[X_W-1], r_low};
    assign wmag  = diff[X_W] ? (~diff + 1'b1) : diff;
    assign fmag  = h_value[VALUE_WIDTH-1] ? (~h_value + 1'b1) : h_value;
    assign conv  = (CMP_W'(fmag) <= CMP_W'(tol)) || (wmag <= (X_W+1)'(tol));

    // no strict sign change across the endpoints
    assign no_sign = (r_flo == '0) || (h_value == '0) ||
                     (r_flo[VALUE_WIDTH-1] == h_value[VALUE_WIDTH-1]);

    assign step_n = r_step + 1'b1;

    // feed the shared unit: low end on accept, high end after it, then midpoints
    always_comb begin
        h_req.kick = 1'b0;
        h_req.x    = i_range_start;
        unique case (r_state)
            S_IDLE: begin
                h_req.kick = accept;
                h_req.x    = i_range_start;
            end
            S_EVAL_LO: begin
                h_req.kick = h_done;
                h_req.x    = r_high;
            end
            S_MID: begin
                h_req.kick = 1'b1;
                h_req.x    = mid_x;
            end
            S_EVAL_HI, S_EVAL_MID: begin
                h_req.kick = 1'b0;
                h_req.x    = r_mid;
            end
            default: begin
                h_req.kick = 1'b0;
                h_req.x    = r_mid;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (accept) n_state = S_EVAL_LO;
            S_EVAL_LO:  if (h_done) n_state = S_EVAL_HI;
            S_EVAL_HI:  if (h_done) n_state = no_sign ? S_IDLE : S_MID;
            S_MID:      n_state = S_EVAL_MID;
            S_EVAL_MID: begin
                if (h_done)
                    n_state = (conv || step_n >= limit) ? S_IDLE : S_MID;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EVAL_HI && h_done && no_sign) ||
                       (r_state == S_EVAL_MID && h_done && (conv || step_n >= limit));
        end
    end

    // interval and result registers carry no reset
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_low  <= i_range_start;
                    r_high <= i_range_end;
                end
            end
            S_EVAL_LO: begin
                if (h_done)
                    r_flo <= h_value;
            end
            S_EVAL_HI: begin
                if (h_done) begin
                    r_low_sign <= r_flo[VALUE_WIDTH-1];
                    r_step     <= '0;
                    if (no_sign) begin
                        r_root       <= '0;
                        r_residual   <= '0;
                        r_steps_used <= '0;
                        r_status     <= ST_NO_SIGN;
                    end
                end
            end
            S_MID: begin
                r_mid <= mid_x;
            end
            S_EVAL_MID: begin
                if (h_done) begin
                    r_step <= step_n;
                    // move the end whose sign f(mid) shares
                    if (h_value[VALUE_WIDTH-1] != r_low_sign)
                        r_high <= r_mid;
                    else
                        r_low  <= r_mid;
                    r_root       <= r_mid;
                    r_residual   <= sat_res(h_value);
                    r_steps_used <= step_n;
                    r_status     <= conv ? ST_CONVERGED : ST_LIMIT;
                end
            end
            default: ;
        endcase
    end

    assign o_done       = r_done;
    assign o_root       = signed'(r_root);
    assign o_residual   = signed'(r_residual);
    assign o_steps_used = r_steps_used;
    assign o_status     = r_status;

    // busy drops only on the result beat
    a_busy_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy fell without a result beat");

    // an accepted request holds the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request taken but block not busy");

    // a search that ran always reports at least one midpoint
    a_steps_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_NO_SIGN) |-> (o_steps_used != '0))
        else $error("bisection result with zero steps");

    // shared unit only finishes while the sequencer waits on it
    a_done_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_done |-> (r_state == S_EVAL_LO || r_state == S_EVAL_HI ||
                    r_state == S_EVAL_MID))
        else $error("evaluation finished outside a wait state");

endmodule
